[rtl/sqch_pkg.sv]
// ----------------------------------------------------------------------------
// sqch_pkg
// shared types, codes and tables of the pulse channel with frequency sweep
// ----------------------------------------------------------------------------
`default_nettype none

package sqch_pkg;

    // command opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_COUNT = 2'd2;
    localparam logic [1:0] OP_WAVE  = 2'd3;

    // register selects
    localparam logic [2:0] SEL_SWEEP    = 3'd0;
    localparam logic [2:0] SEL_DUTY_LEN = 3'd1;
    localparam logic [2:0] SEL_ENVELOPE = 3'd2;
    localparam logic [2:0] SEL_FREQ_LO  = 3'd3;
    localparam logic [2:0] SEL_FREQ_HI  = 3'd4;

    // reset values
    localparam logic [2:0] FRAME_PHASE_RST  = 3'd1;
    localparam logic [7:0] WAVE_PATTERN_RST = 8'h01;
    localparam logic [7:0] ENV_LEVEL_MAX    = 8'd15;

    typedef struct packed {
        logic       channel_enabled;
        logic       wave_bit;
        logic [3:0] drive_level;
        logic [7:0] timer_compare;
        logic [1:0] duty_select;
        logic [7:0] length_count;
        logic [7:0] envelope_volume;
        logic [2:0] envelope_period;
        logic       add_mode;
        logic [7:0] frequency;
        logic       trigger_bit;
        logic       length_enable;
    } status_t;

    // duty waveforms, 12.5 / 25 / 50 / 75 percent
    function automatic logic [7:0] duty_pattern(input logic [1:0] duty);
        logic [7:0] pat;
        unique case (duty)
            2'd0:    pat = 8'b0000_0001;
            2'd1:    pat = 8'b1000_0001;
            2'd2:    pat = 8'b1000_0111;
            default: pat = 8'b0111_1110;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

[rtl/sqch_cmd_if.sv]
// ----------------------------------------------------------------------------
// sqch_cmd_if
// command channel: register writes, frame ticks, counter ticks, wave steps
// ----------------------------------------------------------------------------
`default_nettype none

interface sqch_cmd_if
    import sqch_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [2:0] reg_select;
    logic [7:0] write_data;

    modport source (output valid, output opcode, output reg_select, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input reg_select, input write_data,
                    output ready);
endinterface

`default_nettype wire

[rtl/sqch_status_if.sv]
// ----------------------------------------------------------------------------
// sqch_status_if
// status channel: one beat of channel state per command
// ----------------------------------------------------------------------------
`default_nettype none

interface sqch_status_if
    import sqch_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       channel_enabled;
    logic       wave_bit;
    logic [3:0] drive_level;
    logic [7:0] timer_compare;
    logic [1:0] duty_select;
    logic [7:0] length_count;
    logic [7:0] envelope_volume;
    logic [2:0] envelope_period;
    logic       add_mode;
    logic [7:0] frequency;
    logic       trigger_bit;
    logic       length_enable;

    modport source (output valid, output channel_enabled, output wave_bit,
                    output drive_level, output timer_compare, output duty_select,
                    output length_count, output envelope_volume, output envelope_period,
                    output add_mode, output frequency, output trigger_bit,
                    output length_enable, input ready);
    modport sink   (input valid, input channel_enabled, input wave_bit,
                    input drive_level, input timer_compare, input duty_select,
                    input length_count, input envelope_volume, input envelope_period,
                    input add_mode, input frequency, input trigger_bit,
                    input length_enable, output ready);
endinterface

`default_nettype wire

[rtl/square_channel_with_sweep_core.sv]
// ----------------------------------------------------------------------------
// square_channel_with_sweep_core
// pulse sound channel with frequency sweep, length counter and volume envelope
// ----------------------------------------------------------------------------
// Takes one command beat per clock and returns exactly one status beat per
// command, in the cycle after it is accepted. A command is a register write
// (sweep, duty/length, envelope, frequency low, frequency high with trigger),
// a frame tick, a sequencer count without actions, or a wave step. Frame
// ticks run the length counter on even phases, the sweep on every fourth
// phase and the envelope on phase zero. The whole update of the channel
// state is one pass of logic into the state registers, with the status beat
// held in a single output register; cmd.ready is high whenever that register
// is empty or being drained, so the sustained rate is one command per cycle
// and the only stall comes from back pressure on the status channel.
// ----------------------------------------------------------------------------
`default_nettype none

module square_channel_with_sweep_core
    import sqch_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    sqch_cmd_if.sink     cmd,
    sqch_status_if.source status
);

    // channel state
    logic       enable_reg,       enable_next;
    logic [1:0] duty_reg,         duty_next;
    logic [7:0] length_reg,       length_next;
    logic [7:0] env_volume_reg,   env_volume_next;
    logic [2:0] env_period_reg,   env_period_next;
    logic       env_add_reg,      env_add_next;
    logic [2:0] env_counter_reg,  env_counter_next;
    logic       env_running_reg,  env_running_next;
    logic [7:0] freq_reg,         freq_next;
    logic       trigger_reg,      trigger_next;
    logic       length_on_reg,    length_on_next;
    logic [2:0] sweep_period_reg, sweep_period_next;
    logic       sweep_negate_reg, sweep_negate_next;
    logic [2:0] sweep_shift_reg,  sweep_shift_next;
    logic       sweep_on_reg,     sweep_on_next;
    logic [7:0] shadow_reg,       shadow_next;
    logic [7:0] sweep_timer_reg,  sweep_timer_next;
    logic [2:0] phase_reg,        phase_next;
    logic [7:0] pattern_reg,      pattern_next;
    logic [3:0] level_reg,        level_next;
    logic       pulse_reg,        pulse_next;

    // output stage
    logic       status_valid_reg, status_valid_next;
    status_t    status_reg,       status_next;

    logic       cmd_fire;
    logic [7:0] freq_trig;
    logic [8:0] calc_trig;
    logic [8:0] calc_first;
    logic [8:0] calc_second;
    logic [2:0] env_count_inc;
    logic [7:0] env_volume_step;

    // {overflow, new frequency}; a subtraction never underflows
    function automatic logic [8:0] sweep_calc(input logic [7:0] base,
                                              input logic [2:0] shift,
                                              input logic       negate);
        logic [7:0] delta;
        logic [8:0] sum;
        delta = base >> shift;
        if (negate)
            sum = {1'b0, base - delta};
        else
            sum = {1'b0, base} + {1'b0, delta};
        return sum;
    endfunction

    assign cmd.ready = !status_valid_reg || status.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;

    // frequency after a high write, used by the trigger
    assign freq_trig   = freq_reg | {cmd.write_data[2:0], 5'b0_0000};
    assign calc_trig   = sweep_calc(freq_trig, sweep_shift_reg, sweep_negate_reg);
    // sweep step and its follow-up overflow check on the new value
    assign calc_first  = sweep_calc(shadow_reg, sweep_shift_reg, sweep_negate_reg);
    assign calc_second = sweep_calc(calc_first[7:0], sweep_shift_reg, sweep_negate_reg);

    assign env_count_inc   = env_counter_reg + 3'd1;
    assign env_volume_step = env_add_reg ? env_volume_reg + 8'd1 : env_volume_reg - 8'd1;

    always_comb
    begin
        enable_next       = enable_reg;
        duty_next         = duty_reg;
        length_next       = length_reg;
        env_volume_next   = env_volume_reg;
        env_period_next   = env_period_reg;
        env_add_next      = env_add_reg;
        env_counter_next  = env_counter_reg;
        env_running_next  = env_running_reg;
        freq_next         = freq_reg;
        trigger_next      = trigger_reg;
        length_on_next    = length_on_reg;
        sweep_period_next = sweep_period_reg;
        sweep_negate_next = sweep_negate_reg;
        sweep_shift_next  = sweep_shift_reg;
        sweep_on_next     = sweep_on_reg;
        shadow_next       = shadow_reg;
        sweep_timer_next  = sweep_timer_reg;
        phase_next        = phase_reg;
        pattern_next      = pattern_reg;
        level_next        = level_reg;
        pulse_next        = pulse_reg;

        unique case (cmd.opcode)
            OP_WRITE:
            begin
                unique case (cmd.reg_select)
                    SEL_SWEEP:
                    begin
                        sweep_period_next = cmd.write_data[6:4];
                        sweep_negate_next = cmd.write_data[3];
                        sweep_shift_next  = cmd.write_data[2:0];
                    end
                    SEL_DUTY_LEN:
                    begin
                        duty_next    = cmd.write_data[7:6];
                        length_next  = {2'b00, cmd.write_data[5:0]};
                        pattern_next = duty_pattern(cmd.write_data[7:6]);
                    end
                    SEL_ENVELOPE:
                    begin
                        env_volume_next = {4'h0, cmd.write_data[7:4]};
                        level_next      = cmd.write_data[7:4];
                        env_add_next    = cmd.write_data[3];
                        env_period_next = cmd.write_data[2:0];
                    end
                    SEL_FREQ_LO:
                    begin
                        freq_next = {3'b000, cmd.write_data[7:3]};
                    end
                    SEL_FREQ_HI:
                    begin
                        trigger_next   = cmd.write_data[7];
                        length_on_next = cmd.write_data[6];
                        freq_next      = freq_trig;
                        if (cmd.write_data[7])
                        begin
                            enable_next      = 1'b1;
                            env_running_next = 1'b1;
                            shadow_next      = freq_trig;
                            sweep_timer_next = {5'b0_0000, sweep_period_reg};
                            sweep_on_next    = (sweep_period_reg != 3'd0) ||
                                               (sweep_shift_reg != 3'd0);
                            // immediate overflow check on trigger
                            if ((sweep_shift_reg != 3'd0) && calc_trig[8])
                            begin
                                sweep_on_next = 1'b0;
                                enable_next   = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        // unused selects change nothing
                    end
                endcase
            end
            OP_FRAME:
            begin
                // length counter on even phases
                if (!phase_reg[0] && length_on_reg)
                begin
                    length_next = length_reg - 8'd1;
                    if (length_reg == 8'd1)
                        enable_next = 1'b0;
                end
                // sweep on every fourth phase
                if (phase_reg[1:0] == 2'b00)
                begin
                    sweep_timer_next = sweep_timer_reg - 8'd1;
                    if (sweep_timer_reg == 8'd1)
                    begin
                        sweep_timer_next = {5'b0_0000, sweep_period_reg};
                        if (sweep_on_reg && (sweep_period_reg != 3'd0) &&
                            (sweep_shift_reg != 3'd0))
                        begin
                            if (calc_first[8])
                            begin
                                sweep_on_next = 1'b0;
                                enable_next   = 1'b0;
                            end
                            else
                            begin
                                shadow_next = calc_first[7:0];
                                freq_next   = calc_first[7:0];
                                if (calc_second[8])
                                begin
                                    sweep_on_next = 1'b0;
                                    enable_next   = 1'b0;
                                end
                            end
                        end
                    end
                end
                // envelope on phase zero
                if ((phase_reg == 3'd0) && (env_period_reg != 3'd0) && env_running_reg)
                begin
                    env_counter_next = env_count_inc;
                    if (env_count_inc == env_period_reg)
                    begin
                        env_counter_next = 3'd0;
                        env_volume_next  = env_volume_step;
                        if (env_volume_step <= ENV_LEVEL_MAX)
                            level_next = env_volume_step[3:0];
                        else
                            env_running_next = 1'b0;
                    end
                end
                phase_next = phase_reg + 3'd1;
            end
            OP_COUNT:
            begin
                phase_next = phase_reg + 3'd1;
            end
            default:
            begin
                // wave step: rotate the duty pattern left
                pulse_next   = pattern_reg[7];
                pattern_next = {pattern_reg[6:0], pattern_reg[7]};
            end
        endcase
    end

    // status beat built from the updated state
    always_comb
    begin
        status_next.channel_enabled = enable_next;
        status_next.wave_bit        = pulse_next & enable_next;
        status_next.drive_level     = level_next;
        status_next.timer_compare   = ~freq_next;
        status_next.duty_select     = duty_next;
        status_next.length_count    = length_next;
        status_next.envelope_volume = env_volume_next;
        status_next.envelope_period = env_period_next;
        status_next.add_mode        = env_add_next;
        status_next.frequency       = freq_next;
        status_next.trigger_bit     = trigger_next;
        status_next.length_enable   = length_on_next;
    end

    always_comb
    begin
        if (cmd_fire)
            status_valid_next = 1'b1;
        else if (status.ready)
            status_valid_next = 1'b0;
        else
            status_valid_next = status_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            duty_reg         <= 2'd0;
            length_reg       <= 8'd0;
            env_volume_reg   <= 8'd0;
            env_period_reg   <= 3'd0;
            env_add_reg      <= 1'b0;
            env_counter_reg  <= 3'd0;
            env_running_reg  <= 1'b0;
            freq_reg         <= 8'd0;
            trigger_reg      <= 1'b0;
            length_on_reg    <= 1'b0;
            sweep_period_reg <= 3'd0;
            sweep_negate_reg <= 1'b0;
            sweep_shift_reg  <= 3'd0;
            sweep_on_reg     <= 1'b0;
            shadow_reg       <= 8'd0;
            sweep_timer_reg  <= 8'd0;
            phase_reg        <= FRAME_PHASE_RST;
            pattern_reg      <= WAVE_PATTERN_RST;
            level_reg        <= 4'd0;
            pulse_reg        <= 1'b0;
        end
        else if (cmd_fire)
        begin
            enable_reg       <= enable_next;
            duty_reg         <= duty_next;
            length_reg       <= length_next;
            env_volume_reg   <= env_volume_next;
            env_period_reg   <= env_period_next;
            env_add_reg      <= env_add_next;
            env_counter_reg  <= env_counter_next;
            env_running_reg  <= env_running_next;
            freq_reg         <= freq_next;
            trigger_reg      <= trigger_next;
            length_on_reg    <= length_on_next;
            sweep_period_reg <= sweep_period_next;
            sweep_negate_reg <= sweep_negate_next;
            sweep_shift_reg  <= sweep_shift_next;
            sweep_on_reg     <= sweep_on_next;
            shadow_reg       <= shadow_next;
            sweep_timer_reg  <= sweep_timer_next;
            phase_reg        <= phase_next;
            pattern_reg      <= pattern_next;
            level_reg        <= level_next;
            pulse_reg        <= pulse_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            status_valid_reg <= 1'b0;
        else
            status_valid_reg <= status_valid_next;
    end

    // output payload, loaded with each accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
            status_reg <= status_next;
    end

    assign status.valid           = status_valid_reg;
    assign status.channel_enabled = status_reg.channel_enabled;
    assign status.wave_bit        = status_reg.wave_bit;
    assign status.drive_level     = status_reg.drive_level;
    assign status.timer_compare   = status_reg.timer_compare;
    assign status.duty_select     = status_reg.duty_select;
    assign status.length_count    = status_reg.length_count;
    assign status.envelope_volume = status_reg.envelope_volume;
    assign status.envelope_period = status_reg.envelope_period;
    assign status.add_mode        = status_reg.add_mode;
    assign status.frequency       = status_reg.frequency;
    assign status.trigger_bit     = status_reg.trigger_bit;
    assign status.length_enable   = status_reg.length_enable;

endmodule

`default_nettype wire

[rtl/sqch_checker.sv]
// ----------------------------------------------------------------------------
// sqch_checker
// port-level checks of the pulse channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module sqch_checker
    import sqch_pkg::*;
(
    input wire       clk,
    input wire       rst_n,
    input wire       cmd_valid,
    input wire       cmd_ready,
    input wire       status_valid,
    input wire       status_ready,
    input wire       channel_enabled,
    input wire       wave_bit,
    input wire [7:0] timer_compare,
    input wire [7:0] frequency
);

    // a stalled status beat stays up with the same frequency
    assert property (@(posedge clk) disable iff (!rst_n)
        status_valid && !status_ready |=> status_valid && $stable(frequency))
        else $error("status beat dropped or changed while stalled");

    // an empty output stage never blocks commands
    assert property (@(posedge clk) disable iff (!rst_n)
        !status_valid |-> cmd_ready)
        else $error("command stalled with empty output stage");

    // every accepted command yields a status beat next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> status_valid)
        else $error("accepted command produced no status beat");

    // pulse is gated by the enable and compare tracks frequency
    assert property (@(posedge clk) disable iff (!rst_n)
        status_valid |-> (!wave_bit || channel_enabled) && (timer_compare == ~frequency))
        else $error("status beat fields inconsistent");

endmodule

bind square_channel_with_sweep_core sqch_checker u_sqch_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .status_valid    (status.valid),
    .status_ready    (status.ready),
    .channel_enabled (status.channel_enabled),
    .wave_bit        (status.wave_bit),
    .timer_compare   (status.timer_compare),
    .frequency       (status.frequency)
);

`default_nettype wire

[sim/square_channel_with_sweep_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// square_channel_with_sweep_core_tb
// self-checking bench for the pulse channel with sweep, length and envelope
// ----------------------------------------------------------------------------
// A queue of commands is built at time zero. It holds a directed opening
// followed by random register setups with triggers and bursts of frame ticks,
// wave steps and count-only ticks, mixed with noise. A clocked driver offers
// the commands with random gaps. A clocked monitor runs a bit-exact model of
// the channel on every accepted command and checks every status beat against
// the oldest prediction. The status sink stalls at random and holds off twice
// for a long stretch.
// ----------------------------------------------------------------------------
module square_channel_with_sweep_core_tb;
    import sqch_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 80;

    // one command beat plus a flag that makes the driver wait for an empty pipe
    typedef struct packed {
        bit         drain_first;
        logic [1:0] opcode;
        logic [2:0] reg_select;
        logic [7:0] write_data;
    } command_t;

    logic clk;
    logic rst_n;

    sqch_cmd_if    cmd_bus ();
    sqch_status_if status_bus ();

    square_channel_with_sweep_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_bus),
        .status (status_bus)
    );

    // stimulus and scoreboard
    command_t cmd_queue[$];
    status_t  expected_status[$];
    int       useful_queued;
    int       total_commands;
    int       commands_sent;
    int       beats_received;
    int       error_count;
    int       cycle_count;

    // handshake flags seen at the last rising edge
    logic cmd_taken;
    logic beat_taken;

    // driver and sink pacing
    int send_gap;
    bit send_burst;
    int stall_left;
    int hold_left;
    int stall_draw;
    bit recv_burst;

    // channel model state
    logic       ch_enable;
    logic [1:0] ch_duty;
    logic [7:0] ch_length;
    logic [7:0] ch_env_vol;
    logic [2:0] ch_env_per;
    logic       ch_env_add;
    logic [2:0] ch_env_cnt;
    logic       ch_env_run;
    logic [7:0] ch_freq;
    logic       ch_trigger;
    logic       ch_len_on;
    logic [2:0] ch_sweep_per;
    logic       ch_sweep_neg;
    logic [2:0] ch_sweep_shift;
    logic       ch_sweep_on;
    logic [7:0] ch_shadow;
    logic [7:0] ch_sweep_timer;
    logic [2:0] ch_phase;
    logic [7:0] ch_pattern;
    logic [3:0] ch_level;
    logic       ch_pulse;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // channel model
    // ------------------------------------------------------------------------

    // one sweep calculation from the shadow frequency; an overflow past 255
    // switches the sweep and the channel off
    function automatic logic [7:0] sweep_target(output logic overflow);
        logic [8:0] base;
        logic [8:0] delta;
        logic [8:0] sum;
        base     = {1'b0, ch_shadow};
        delta    = base >> ch_sweep_shift;
        sum      = ch_sweep_neg ? base - delta : base + delta;
        overflow = sum[8];
        if (overflow)
        begin
            ch_sweep_on = 1'b0;
            ch_enable   = 1'b0;
        end
        return sum[7:0];
    endfunction

    // advance the model by one command and return the status beat it yields
    function automatic status_t channel_step(input command_t c);
        logic       ovf;
        logic [7:0] swept;
        status_t    s;
        case (c.opcode)
            OP_WRITE:
            begin
                case (c.reg_select)
                    SEL_SWEEP:
                    begin
                        ch_sweep_per   = c.write_data[6:4];
                        ch_sweep_neg   = c.write_data[3];
                        ch_sweep_shift = c.write_data[2:0];
                    end
                    SEL_DUTY_LEN:
                    begin
                        ch_duty   = c.write_data[7:6];
                        ch_length = {2'b00, c.write_data[5:0]};
                        // duty waveform reloads the rotating pattern
                        case (ch_duty)
                            2'd0:    ch_pattern = 8'h01;
                            2'd1:    ch_pattern = 8'h81;
                            2'd2:    ch_pattern = 8'h87;
                            default: ch_pattern = 8'h7E;
                        endcase
                    end
                    SEL_ENVELOPE:
                    begin
                        // counter and running flag are left alone
                        ch_env_vol = {4'h0, c.write_data[7:4]};
                        ch_level   = c.write_data[7:4];
                        ch_env_add = c.write_data[3];
                        ch_env_per = c.write_data[2:0];
                    end
                    SEL_FREQ_LO:
                        ch_freq = {3'b000, c.write_data[7:3]};
                    SEL_FREQ_HI:
                    begin
                        ch_trigger = c.write_data[7];
                        ch_len_on  = c.write_data[6];
                        ch_freq    = ch_freq | {c.write_data[2:0], 5'b00000};
                        if (ch_trigger)
                        begin
                            // enable first, the immediate overflow check may undo it
                            ch_enable      = 1'b1;
                            ch_env_run     = 1'b1;
                            ch_shadow      = ch_freq;
                            ch_sweep_timer = {5'b00000, ch_sweep_per};
                            ch_sweep_on    = (ch_sweep_per != 3'd0) || (ch_sweep_shift != 3'd0);
                            if (ch_sweep_shift != 3'd0)
                                void'(sweep_target(ovf));
                        end
                    end
                    default:
                    begin
                        // unused selects change nothing
                    end
                endcase
            end
            OP_FRAME:
            begin
                // length counter on even phases, wraps from zero to 255
                if (!ch_phase[0] && ch_len_on)
                begin
                    ch_length = ch_length - 8'd1;
                    if (ch_length == 8'd0)
                        ch_enable = 1'b0;
                end
                // sweep on phases 0 and 4, a zero period wraps the timer to 255
                if (ch_phase[1:0] == 2'd0)
                begin
                    ch_sweep_timer = ch_sweep_timer - 8'd1;
                    if (ch_sweep_timer == 8'd0)
                    begin
                        ch_sweep_timer = {5'b00000, ch_sweep_per};
                        if (ch_sweep_on && ch_sweep_per != 3'd0 && ch_sweep_shift != 3'd0)
                        begin
                            swept = sweep_target(ovf);
                            if (!ovf)
                            begin
                                ch_shadow = swept;
                                ch_freq   = swept;
                                void'(sweep_target(ovf));
                            end
                        end
                    end
                end
                // envelope on phase 0; a step out of 0..15 stops it
                if (ch_phase == 3'd0 && ch_env_per != 3'd0 && ch_env_run)
                begin
                    ch_env_cnt = ch_env_cnt + 3'd1;
                    if (ch_env_cnt == ch_env_per)
                    begin
                        ch_env_cnt = 3'd0;
                        ch_env_vol = ch_env_add ? ch_env_vol + 8'd1 : ch_env_vol - 8'd1;
                        if (ch_env_vol <= 8'd15)
                            ch_level = ch_env_vol[3:0];
                        else
                            ch_env_run = 1'b0;
                    end
                end
                ch_phase = ch_phase + 3'd1;
            end
            OP_COUNT:
                ch_phase = ch_phase + 3'd1;
            default:
            begin
                // wave step: rotate left, the bit leaving the top is the pulse
                ch_pulse   = ch_pattern[7];
                ch_pattern = {ch_pattern[6:0], ch_pattern[7]};
            end
        endcase

        s.channel_enabled = ch_enable;
        s.wave_bit        = ch_pulse & ch_enable;
        s.drive_level     = ch_level;
        s.timer_compare   = 8'hFF - ch_freq;
        s.duty_select     = ch_duty;
        s.length_count    = ch_length;
        s.envelope_volume = ch_env_vol;
        s.envelope_period = ch_env_per;
        s.add_mode        = ch_env_add;
        s.frequency       = ch_freq;
        s.trigger_bit     = ch_trigger;
        s.length_enable   = ch_len_on;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // error reporting
    // ------------------------------------------------------------------------
    task automatic report_error(input string msg);
        error_count = error_count + 1;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("beat %0d %s: got %0h, expected %0h",
                                   beats_received, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // writes to unused selects are ignored by the block and not counted
    task automatic queue_command(input logic [1:0] op, input logic [2:0] sel,
                                 input logic [7:0] data, input bit drain);
        command_t c;
        c.drain_first = drain;
        c.opcode      = op;
        c.reg_select  = sel;
        c.write_data  = data;
        cmd_queue.push_back(c);
        if (op != OP_WRITE || sel <= SEL_FREQ_HI)
            useful_queued = useful_queued + 1;
    endtask

    task automatic queue_event(input logic [1:0] op);
        queue_command(op, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // monitor: predicts on accepted commands, checks accepted status beats
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        command_t accepted;
        status_t  got;
        status_t  want;
        if (!rst_n)
        begin
            cmd_taken      <= 1'b0;
            beat_taken     <= 1'b0;
            commands_sent  <= 0;
            beats_received <= 0;
            // model back to its reset state
            ch_enable      = 1'b0;
            ch_duty        = 2'd0;
            ch_length      = 8'd0;
            ch_env_vol     = 8'd0;
            ch_env_per     = 3'd0;
            ch_env_add     = 1'b0;
            ch_env_cnt     = 3'd0;
            ch_env_run     = 1'b0;
            ch_freq        = 8'd0;
            ch_trigger     = 1'b0;
            ch_len_on      = 1'b0;
            ch_sweep_per   = 3'd0;
            ch_sweep_neg   = 1'b0;
            ch_sweep_shift = 3'd0;
            ch_sweep_on    = 1'b0;
            ch_shadow      = 8'd0;
            ch_sweep_timer = 8'd0;
            ch_phase       = FRAME_PHASE_RST;
            ch_pattern     = WAVE_PATTERN_RST;
            ch_level       = 4'd0;
            ch_pulse       = 1'b0;
        end
        else
        begin
            cmd_taken  <= cmd_bus.valid && cmd_bus.ready;
            beat_taken <= status_bus.valid && status_bus.ready;

            // predict first so a same-edge beat could still find its entry
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                accepted = {1'b0, cmd_bus.opcode, cmd_bus.reg_select, cmd_bus.write_data};
                expected_status.push_back(channel_step(accepted));
                commands_sent <= commands_sent + 1;
            end

            if (status_bus.valid && status_bus.ready)
            begin
                beats_received <= beats_received + 1;
                if (expected_status.size() == 0)
                    report_error($sformatf("status beat %0d with no command pending",
                                           beats_received));
                else
                begin
                    want = expected_status.pop_front();
                    got  = {status_bus.channel_enabled, status_bus.wave_bit,
                            status_bus.drive_level, status_bus.timer_compare,
                            status_bus.duty_select, status_bus.length_count,
                            status_bus.envelope_volume, status_bus.envelope_period,
                            status_bus.add_mode, status_bus.frequency,
                            status_bus.trigger_bit, status_bus.length_enable};
                    check_field("channel_enabled", 8'(got.channel_enabled),
                                8'(want.channel_enabled));
                    check_field("wave_bit", 8'(got.wave_bit), 8'(want.wave_bit));
                    check_field("drive_level", 8'(got.drive_level), 8'(want.drive_level));
                    check_field("timer_compare", got.timer_compare, want.timer_compare);
                    check_field("duty_select", 8'(got.duty_select), 8'(want.duty_select));
                    check_field("length_count", got.length_count, want.length_count);
                    check_field("envelope_volume", got.envelope_volume,
                                want.envelope_volume);
                    check_field("envelope_period", 8'(got.envelope_period),
                                8'(want.envelope_period));
                    check_field("add_mode", 8'(got.add_mode), 8'(want.add_mode));
                    check_field("frequency", got.frequency, want.frequency);
                    check_field("trigger_bit", 8'(got.trigger_bit), 8'(want.trigger_bit));
                    check_field("length_enable", 8'(got.length_enable),
                                8'(want.length_enable));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // command driver: changes on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        command_t c;
        if (rst_n)
        begin
            // the slot is free when nothing is offered or the last beat went in
            if (!cmd_bus.valid || cmd_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap      <= send_gap - 1;
                    cmd_bus.valid <= 1'b0;
                end
                else if (cmd_queue.size() > 0 &&
                         (!cmd_queue[0].drain_first || expected_status.size() == 0))
                begin
                    c = cmd_queue.pop_front();
                    cmd_bus.opcode     <= c.opcode;
                    cmd_bus.reg_select <= c.reg_select;
                    cmd_bus.write_data <= c.write_data;
                    cmd_bus.valid      <= 1'b1;
                    // gap after this beat; bursts with no gaps now and then
                    send_gap <= send_burst ? 0 : $urandom_range(0, 7);
                    if ($urandom_range(0, 39) == 0)
                        send_burst <= ~send_burst;
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // status sink: random stalls per beat, two long hold-offs
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : sink
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left        <= hold_left - 1;
                status_bus.ready <= 1'b0;
            end
            else if (beat_taken && (beats_received == 300 || beats_received == 900))
            begin
                // long hold-off: the block fills up and must stall its input
                hold_left        <= LONG_HOLD;
                status_bus.ready <= 1'b0;
            end
            else if (beat_taken)
            begin
                stall_draw = recv_burst ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 39) == 0)
                    recv_burst <= ~recv_burst;
                if (stall_draw == 0)
                    status_bus.ready <= 1'b1;
                else
                begin
                    stall_left       <= stall_draw - 1;
                    status_bus.ready <= 1'b0;
                end
            end
            else if (stall_left > 0)
            begin
                stall_left       <= stall_left - 1;
                status_bus.ready <= 1'b0;
            end
            else
                status_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("square_channel_with_sweep_core_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin : main
        int   random_start;
        int   burst_len;
        int   roll;
        bit   drained_mid;
        bit   first_seq;
        logic [7:0] data;

        // every input known from time zero
        rst_n                 = 1'b0;
        cmd_bus.valid         = 1'b0;
        cmd_bus.opcode        = OP_WRITE;
        cmd_bus.reg_select    = SEL_SWEEP;
        cmd_bus.write_data    = 8'd0;
        status_bus.ready      = 1'b0;
        useful_queued         = 0;
        error_count           = 0;
        cycle_count           = 0;
        send_gap              = 0;
        send_burst            = 1'b0;
        stall_left            = 0;
        hold_left             = 0;
        recv_burst            = 1'b0;
        drained_mid           = 1'b0;
        first_seq             = 1'b1;

        // directed: reset pattern, full-scale writes, then the special cases
        queue_event(OP_WAVE);                              // pulse from reset pattern
        queue_event(OP_COUNT);                             // phase 1 -> 2, no actions
        queue_command(OP_WRITE, SEL_DUTY_LEN, 8'hFF, 1'b0);
        queue_command(OP_WRITE, SEL_ENVELOPE, 8'hFF, 1'b0);
        queue_command(OP_WRITE, SEL_SWEEP,    8'hFF, 1'b0);
        queue_command(OP_WRITE, SEL_FREQ_LO,  8'hFF, 1'b0);
        queue_command(OP_WRITE, SEL_FREQ_HI,  8'hFF, 1'b0); // trigger, negate, no overflow
        queue_event(OP_WAVE);
        queue_event(OP_WAVE);
        // overflow right at the trigger: 255 + 127
        queue_command(OP_WRITE, SEL_SWEEP,    8'h11, 1'b0);
        queue_command(OP_WRITE, SEL_FREQ_LO,  8'hF8, 1'b0);
        queue_command(OP_WRITE, SEL_FREQ_HI,  8'h87, 1'b0);
        // zero sweep period: timer wraps to 255 on the next sweep tick
        queue_command(OP_WRITE, SEL_SWEEP,    8'h01, 1'b0);
        queue_command(OP_WRITE, SEL_FREQ_LO,  8'h00, 1'b0);
        queue_command(OP_WRITE, SEL_FREQ_HI,  8'h81, 1'b0);
        repeat (3) queue_event(OP_FRAME);                  // phases 2, 3, 4
        // length runs out, then wraps from zero; envelope climbs past 15
        queue_command(OP_WRITE, SEL_DUTY_LEN, 8'h41, 1'b0);
        queue_command(OP_WRITE, SEL_ENVELOPE, 8'hF9, 1'b0);
        queue_command(OP_WRITE, SEL_FREQ_HI,  8'hC0, 1'b0);
        repeat (4) queue_event(OP_FRAME);                  // phases 5, 6, 7, 0
        // unused selects
        queue_command(OP_WRITE, 3'd5, 8'hFF, 1'b0);
        queue_command(OP_WRITE, 3'd7, 8'hAA, 1'b0);

        // random: register setup, trigger, burst of ticks; some noise between
        random_start = useful_queued;
        while (useful_queued - random_start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    queue_command(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                                  8'($urandom_range(0, 255)), 1'b0);
            end
            else
            begin
                // sender waits for an empty pipe at the start and once midway
                if (first_seq || (!drained_mid && useful_queued - random_start > 650))
                begin
                    queue_command(OP_COUNT, 3'($urandom_range(0, 7)),
                                  8'($urandom_range(0, 255)), 1'b1);
                    if (!first_seq)
                        drained_mid = 1'b1;
                    first_seq = 1'b0;
                end
                if ($urandom_range(0, 9) < 7)
                    queue_command(OP_WRITE, SEL_SWEEP, 8'($urandom_range(0, 255)), 1'b0);
                if ($urandom_range(0, 9) < 7)
                begin
                    data = 8'($urandom_range(0, 255));
                    // short lengths half of the time so they run out
                    if ($urandom_range(0, 1) == 0)
                        data[5:0] = 6'($urandom_range(0, 7));
                    queue_command(OP_WRITE, SEL_DUTY_LEN, data, 1'b0);
                end
                if ($urandom_range(0, 9) < 7)
                begin
                    data = 8'($urandom_range(0, 255));
                    // short envelope periods so steps happen within a burst
                    if ($urandom_range(0, 3) != 0)
                        data[2:0] = 3'($urandom_range(0, 2));
                    queue_command(OP_WRITE, SEL_ENVELOPE, data, 1'b0);
                end
                if ($urandom_range(0, 9) < 7)
                    queue_command(OP_WRITE, SEL_FREQ_LO, 8'($urandom_range(0, 255)), 1'b0);
                data    = 8'($urandom_range(0, 255));
                data[7] = ($urandom_range(0, 9) != 0);
                queue_command(OP_WRITE, SEL_FREQ_HI, data, 1'b0);

                burst_len = $urandom_range(8, 40);
                repeat (burst_len)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 60)
                        queue_event(OP_FRAME);
                    else if (roll < 85)
                        queue_event(OP_WAVE);
                    else if (roll < 95)
                        queue_event(OP_COUNT);
                    else
                        queue_command(OP_WRITE, 3'($urandom_range(0, 7)),
                                      8'($urandom_range(0, 255)), 1'b0);
                end
            end
        end
        total_commands = cmd_queue.size();

        // reset, released on a falling edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // all commands in, all beats back, then a few quiet cycles
        while (commands_sent < total_commands)
            @(negedge clk);
        while (expected_status.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("square_channel_with_sweep_core_tb: clean");
        else
            $display("square_channel_with_sweep_core_tb: errors");
        $finish;
    end

endmodule

[sim.f]
rtl/sqch_pkg.sv
rtl/sqch_cmd_if.sv
rtl/sqch_status_if.sv
rtl/square_channel_with_sweep_core.sv
rtl/sqch_checker.sv
sim/square_channel_with_sweep_core_tb.sv
